[rtl/bole_pkg.sv]
// Package for the bounded ordered list engine: sizes, request and status codes,
// controller states and the command/status structs. No dependencies.
package bole_pkg;
	localparam int CAPACITY = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		REQ_INSERT_AT = 3'd0, REQ_INSERT_SORTED = 3'd1, REQ_DELETE_AT = 3'd2,
		REQ_DELETE_EQUAL = 3'd3, REQ_SEARCH = 3'd4, REQ_EXTRACT_MIN = 3'd5,
		REQ_NONE6 = 3'd6, REQ_NONE7 = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_BADPOS = 3'd2, ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN, S_SEEK, S_SHUP_RD, S_SHUP, S_PUT,
		S_SHDN_RD, S_SHDN, S_CMP_RD, S_CMP, S_DONE, S_REPLY
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // capture request
		logic shup_rd;    // read entry[cur-1] for a shift-up
		logic shdn_rd;    // read entry[cur+1] for a shift-down
		logic scan_step;  // consume read data in a scan (search / sorted / min / delete_at)
		logic put;        // write request value at target
		logic shup_step;  // move entry[cur-1] to entry[cur]
		logic shdn_step;  // move entry[cur+1] to entry[cur]
		logic cmp_step;   // compaction step
		logic cur_to_tgt;
		logic cur_to_top;
		logic cur_to_zero;
		logic set_err;
		status_t err;
		logic finish;
	} bole_cmd_t;

	// Datapath to controller
	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic ins_pos_bad;
		logic del_pos_bad;
		logic scan_last;   // cursor at last valid entry
		logic scan_stop;   // sorted scan found greater, or search hit
		logic shup_done;   // cursor == target
		logic shdn_done;   // cursor + 1 >= count
	} bole_stat_t;
endpackage

[rtl/bole_ram.sv]
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module bole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/bole_datapath.sv]
// Datapath of the list engine: entry RAM, count, cursor, scan and result registers.
// Depends on bole_pkg and bole_ram.
module bole_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    req_type,
	input  logic [4:0]                    position,
	input  logic signed [31:0]            value,
	input  bole_pkg::bole_cmd_t           cmd,
	output bole_pkg::bole_stat_t          stat,
	output logic [2:0]                    status,
	output logic signed [31:0]            out_value,
	output logic [4:0]                    out_position,
	output logic [4:0]                    removed_count,
	output logic [4:0]                    entry_count
);
	import bole_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cur_q;     // read/move cursor
	logic [CNT_W-1:0] tgt_q;     // target index
	logic [CNT_W-1:0] wr_q;      // compaction write index
	logic [CNT_W-1:0] nrem_q;
	req_t             req_q;
	logic [4:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] min_q;
	logic             found_q;
	status_t          st_q;

	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [VALUE_WIDTH-1:0] wdata, rdata;

	logic signed [VALUE_WIDTH-1:0] rd_s, val_s, min_s;
	logic [CNT_W:0] pos_ext;
	logic hit, greater, lesser;

	assign rd_s  = rdata;
	assign val_s = val_q;
	assign min_s = min_q;
	assign hit     = (rdata == val_q);
	assign greater = rd_s > val_s;
	assign lesser  = rd_s < min_s;
	assign pos_ext = (CNT_W + 1)'(pos_q);

	// Shifts read the neighbour in the cycle before the write at the cursor.
	always_comb begin
		raddr = cur_q[IDX_W-1:0];
		if (cmd.shup_rd) begin
			raddr = IDX_W'(cur_q - 1'b1);
		end else if (cmd.shdn_rd) begin
			raddr = IDX_W'(cur_q + 1'b1);
		end
		we = 1'b0;
		waddr = cur_q[IDX_W-1:0];
		wdata = rdata;
		if (cmd.put) begin
			we = 1'b1;
			waddr = tgt_q[IDX_W-1:0];
			wdata = val_q;
		end else if (cmd.shup_step || cmd.shdn_step) begin
			we = 1'b1;
		end else if (cmd.cmp_step && !hit) begin
			we = 1'b1;
			waddr = wr_q[IDX_W-1:0];
		end
	end

	bole_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.put) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.finish && st_q == ST_OK &&
				(req_q == REQ_DELETE_AT || req_q == REQ_EXTRACT_MIN)) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.finish && req_q == REQ_DELETE_EQUAL && st_q != ST_EMPTY) begin
			cnt_q <= wr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_t'(req_type);
			pos_q   <= position;
			val_q   <= value;
			st_q    <= ST_OK;
			found_q <= 1'b0;
			nrem_q  <= '0;
			wr_q    <= '0;
			tgt_q   <= (req_t'(req_type) == REQ_INSERT_SORTED) ? '0 :
			           CNT_W'(position) - 1'b1;
			out_value <= '0;
			out_position <= '0;
		end
		if (cmd.set_err) begin
			st_q <= cmd.err;
		end
		if (cmd.cur_to_zero) begin
			cur_q <= '0;
		end else if (cmd.cur_to_top) begin
			cur_q <= cnt_q;
		end else if (cmd.cur_to_tgt) begin
			cur_q <= tgt_q;
		end else if (cmd.shup_step) begin
			cur_q <= cur_q - 1'b1;
		end else if (cmd.shdn_step || cmd.scan_step || cmd.cmp_step) begin
			cur_q <= cur_q + 1'b1;
		end
		if (cmd.scan_step) begin
			case (req_q)
				REQ_INSERT_SORTED: begin
					if (!greater) tgt_q <= cur_q + 1'b1;
				end
				REQ_SEARCH: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
						tgt_q <= cur_q;
					end
				end
				REQ_EXTRACT_MIN: begin
					if (cur_q == '0 || lesser) begin
						min_q <= rdata;
						tgt_q <= cur_q;
					end
				end
				default: ;
			endcase
		end
		if (cmd.cmp_step) begin
			if (hit) nrem_q <= nrem_q + 1'b1;
			else wr_q <= wr_q + 1'b1;
		end
		if (cmd.finish) begin
			case (req_q)
				REQ_DELETE_AT: if (st_q == ST_OK) out_value <= min_q;
				REQ_EXTRACT_MIN: begin
					if (st_q == ST_OK) begin
						out_value <= min_q;
						out_position <= 5'(tgt_q + 1'b1);
					end
				end
				REQ_SEARCH: begin
					if (st_q == ST_OK) begin
						if (found_q) out_position <= 5'(tgt_q + 1'b1);
						else st_q <= ST_NOTFOUND;
					end
				end
				REQ_DELETE_EQUAL: if (st_q == ST_OK && nrem_q == '0) st_q <= ST_NOTFOUND;
				default: ;
			endcase
		end
		// delete_at captures the removed entry from its single read at the target
		if (cmd.scan_step && req_q == REQ_DELETE_AT) begin
			min_q <= rdata;
		end
	end

	assign stat.req         = req_q;
	assign stat.full        = (cnt_q >= CNT_W'(CAPACITY));
	assign stat.empty       = (cnt_q == '0);
	assign stat.ins_pos_bad = (pos_q == 5'd0) || (pos_ext > (CNT_W + 1)'(cnt_q) + 1'b1);
	assign stat.del_pos_bad = (pos_q == 5'd0) || (pos_ext > (CNT_W + 1)'(cnt_q));
	assign stat.scan_last   = ((CNT_W + 1)'(cur_q) + 1'b1 >= (CNT_W + 1)'(cnt_q));
	assign stat.scan_stop   = (req_q == REQ_INSERT_SORTED) ? greater :
	                          (req_q == REQ_SEARCH) ? hit : 1'b0;
	assign stat.shup_done   = (cur_q == tgt_q);
	assign stat.shdn_done   = ((CNT_W + 1)'(cur_q) + 1'b1 >= (CNT_W + 1)'(cnt_q));

	assign status        = st_q;
	assign removed_count = (req_q == REQ_DELETE_EQUAL && st_q != ST_EMPTY) ? 5'(nrem_q) : 5'd0;
	assign entry_count   = 5'(cnt_q);
endmodule

[rtl/bole_ctrl.sv]
// Controller state machine of the list engine.
// Depends on bole_pkg.
module bole_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  bole_pkg::bole_stat_t stat,
	output bole_pkg::bole_cmd_t  cmd
);
	import bole_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_CHECK;
			S_CHECK: begin
				case (stat.req)
					REQ_INSERT_AT:
						state_d = (stat.full || stat.ins_pos_bad) ? S_DONE : S_SHUP_RD;
					REQ_INSERT_SORTED:
						state_d = stat.full ? S_DONE : (stat.empty ? S_SHUP_RD : S_SCAN_RD);
					REQ_DELETE_AT:
						state_d = (stat.empty || stat.del_pos_bad) ? S_DONE : S_SCAN_RD;
					REQ_SEARCH, REQ_EXTRACT_MIN:
						state_d = stat.empty ? S_DONE : S_SCAN_RD;
					REQ_DELETE_EQUAL:
						state_d = stat.empty ? S_DONE : S_CMP_RD;
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: begin
				if (stat.req == REQ_DELETE_AT) state_d = S_SHDN_RD;
				else if (stat.scan_last || stat.scan_stop) begin
					if (stat.req == REQ_INSERT_SORTED) state_d = S_SHUP_RD;
					else if (stat.req == REQ_EXTRACT_MIN) state_d = S_SEEK;
					else state_d = S_DONE;
				end else state_d = S_SCAN_RD;
			end
			S_SEEK:    state_d = S_SHDN_RD;
			S_SHUP_RD: state_d = stat.shup_done ? S_PUT : S_SHUP;
			S_SHUP:    state_d = S_SHUP_RD;
			S_PUT:     state_d = S_DONE;
			S_SHDN_RD: state_d = stat.shdn_done ? S_DONE : S_SHDN;
			S_SHDN:    state_d = S_SHDN_RD;
			S_CMP_RD:  state_d = S_CMP;
			S_CMP:     state_d = stat.scan_last ? S_DONE : S_CMP_RD;
			S_DONE:    state_d = S_REPLY;
			S_REPLY:   state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.err = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				cmd.cur_to_zero = start;
			end
			S_CHECK: begin
				case (stat.req)
					REQ_INSERT_AT: begin
						cmd.set_err = stat.full || stat.ins_pos_bad;
						cmd.err = stat.full ? ST_FULL : ST_BADPOS;
						cmd.cur_to_top = 1'b1;
					end
					REQ_INSERT_SORTED: begin
						cmd.set_err = stat.full;
						cmd.err = ST_FULL;
						cmd.cur_to_top = stat.empty;
					end
					REQ_DELETE_AT: begin
						cmd.set_err = stat.empty || stat.del_pos_bad;
						cmd.err = stat.empty ? ST_EMPTY : ST_BADPOS;
						cmd.cur_to_tgt = 1'b1;
					end
					REQ_SEARCH, REQ_EXTRACT_MIN, REQ_DELETE_EQUAL: begin
						cmd.set_err = stat.empty;
						cmd.err = ST_EMPTY;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.req == REQ_DELETE_AT) cmd.cur_to_tgt = 1'b1;
				else if (stat.scan_last || stat.scan_stop) begin
					if (stat.req == REQ_INSERT_SORTED) cmd.cur_to_top = 1'b1;
				end
			end
			// extract_min: start the shift-down at the minimum once the scan has settled
			S_SEEK: cmd.cur_to_tgt = 1'b1;
			S_SHUP_RD: cmd.shup_rd = 1'b1;
			S_SHDN_RD: cmd.shdn_rd = 1'b1;
			S_SHUP: cmd.shup_step = 1'b1;
			S_SHDN: cmd.shdn_step = 1'b1;
			S_PUT: cmd.put = 1'b1;
			S_CMP: cmd.cmp_step = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_REPLY);
endmodule

[rtl/bounded_ordered_list_engine_top.sv]
// Top level of the bounded ordered list engine: controller plus datapath.
// Depends on bole_pkg, bole_ctrl, bole_datapath.

// A request is taken when start is high and busy is low; its result appears
// on the result ports, marked by done, for a single cycle and must be taken
// then, as the receiver cannot stall. Busy covers the whole transaction, done
// is its last cycle, and a new request can be taken from the cycle after.
// Each scan, shift or compaction step reads the single entry RAM port and
// uses the data the cycle after, so a transaction walks its entries in
// pairs of read and step states. Error replies go from the check straight to
// the done and reply states; extract-min of the head of a full list is the
// longest (a full scan, then a shift-down of the other 15 entries).
module bounded_ordered_list_engine_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] out_value,
	output logic [4:0]         out_position,
	output logic [4:0]         removed_count,
	output logic [4:0]         entry_count
);
	import bole_pkg::*;

	bole_cmd_t  cmd;
	bole_stat_t stat;

	bole_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.stat(stat), .cmd(cmd)
	);

	bole_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req_type(req_type), .position(position),
		.value(value), .cmd(cmd), .stat(stat), .status(status),
		.out_value(out_value), .out_position(out_position),
		.removed_count(removed_count), .entry_count(entry_count)
	);
endmodule

[rtl/bole_checker.sv]
// Port-level checker for the list engine, bound to the top level.
// Depends on bole_pkg.
module bole_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status,
	input logic [4:0] entry_count
);
	import bole_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("done longer than one cycle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= 5'(CAPACITY)) else $error("entry count above capacity");
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK && status != ST_NOTFOUND |-> $stable(entry_count))
		else $error("error changed the count");
endmodule

bind bounded_ordered_list_engine_top bole_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .entry_count(entry_count)
);

[tb/bounded_ordered_list_engine_checker.sv]
// Checker for the bounded ordered list engine: models the list, predicts each
// result and compares it with the done strobe. Depends on bole_pkg.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         req_type,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	input  logic               done,
	input  logic [2:0]         status,
	input  logic signed [31:0] out_value,
	input  logic [4:0]         out_position,
	input  logic [4:0]         removed_count,
	input  logic [4:0]         entry_count,
	output int                 fail_count,
	output int                 pending
);
	import bole_pkg::*;

	typedef struct packed {
		status_t            st;
		logic signed [31:0] val;
		logic [4:0]         pos;
		logic [4:0]         nrem;
		logic [4:0]         cnt;
	} reply_t;

	logic signed [31:0] list_q[$];
	reply_t replies_q[$];

	assign pending = replies_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic reply_t apply_request(input req_t rq, input logic [4:0] p,
			input logic signed [31:0] v);
		reply_t r;
		int i, k, n;
		r = '0;
		r.st = ST_OK;
		n = list_q.size();
		case (rq)
			REQ_INSERT_AT:
				if (n >= CAPACITY) r.st = ST_FULL;
				else if (p == 0 || p > n + 1) r.st = ST_BADPOS;
				else list_q.insert(p - 1, v);
			REQ_INSERT_SORTED:
				if (n >= CAPACITY) r.st = ST_FULL;
				else begin
					i = 0;
					while (i < n && list_q[i] <= v) i++;
					list_q.insert(i, v);
				end
			REQ_DELETE_AT:
				if (n == 0) r.st = ST_EMPTY;
				else if (p == 0 || p > n) r.st = ST_BADPOS;
				else begin
					r.val = list_q[p - 1];
					list_q.delete(p - 1);
				end
			REQ_DELETE_EQUAL:
				if (n == 0) r.st = ST_EMPTY;
				else begin
					for (i = n - 1; i >= 0; i--)
						if (list_q[i] == v) begin
							list_q.delete(i);
							r.nrem++;
						end
					if (r.nrem == 0) r.st = ST_NOTFOUND;
				end
			REQ_SEARCH:
				if (n == 0) r.st = ST_EMPTY;
				else begin
					r.st = ST_NOTFOUND;
					for (i = 0; i < n; i++)
						if (list_q[i] == v) begin
							r.pos = 5'(i + 1);
							r.st = ST_OK;
							break;
						end
				end
			REQ_EXTRACT_MIN:
				if (n == 0) r.st = ST_EMPTY;
				else begin
					k = 0;
					for (i = 1; i < n; i++)
						if (list_q[i] < list_q[k]) k = i;
					r.pos = 5'(k + 1);
					r.val = list_q[k];
					list_q.delete(k);
				end
			default: ;
		endcase
		r.cnt = 5'(list_q.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t w;
		if (!arst_n) begin
			list_q.delete();
			replies_q.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (replies_q.size() == 0) begin
					$display("%0t: result with nothing outstanding", $time);
					fail_count++;
				end else begin
					w = replies_q.pop_front();
					if (status !== w.st) report("status", 32'(status), 32'(w.st));
					if (out_value !== w.val) report("out_value", out_value, w.val);
					if (out_position !== w.pos)
						report("out_position", 32'(out_position), 32'(w.pos));
					if (removed_count !== w.nrem)
						report("removed_count", 32'(removed_count), 32'(w.nrem));
					if (entry_count !== w.cnt)
						report("entry_count", 32'(entry_count), 32'(w.cnt));
				end
			end
			if (start && !busy)
				replies_q.push_back(apply_request(req_t'(req_type), position, value));
		end
	end
endmodule

[tb/bounded_ordered_list_engine_top_tb.sv]
// Testbench top for the bounded ordered list engine: drives requests and gives
// the verdict. Depends on bole_pkg, the engine and its checker.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_top_tb;
	import bole_pkg::*;

	localparam int RANDOM_ITEMS = 1730;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] req_type = '0;
	logic [4:0] position = '0;
	logic signed [31:0] value = '0;
	logic busy, done;
	logic [2:0] status;
	logic signed [31:0] out_value;
	logic [4:0] out_position, removed_count, entry_count;
	int fail_count, pending, cycles;
	int held;
	logic signed [31:0] recent[8];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	bounded_ordered_list_engine_top DUT (.*);

	bounded_ordered_list_engine_checker u_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// One transaction: wait a random gap, present it for one accepting edge,
	// then wait for the reply so the list size is known for the next one.
	task automatic issue(input req_t rq, input logic [4:0] p, input logic signed [31:0] v);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
		repeat (gap) @(negedge clk);
		req_type <= rq;
		position <= p;
		value <= v;
		start <= 1'b1;
		// busy is low here, so the transaction is taken at the next rising edge
		@(negedge clk);
		start <= 1'b0;
		while (busy) @(negedge clk);
		held = int'(entry_count);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return recent[$urandom_range(0, 7)];
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return $urandom_range(0, 6) - 3;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic signed [31:0] v;
		int r;
		req_t rq;
		held = 0;
		for (int i = 0; i < 8; i++) recent[i] = $urandom;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list errors, then edge values, bad positions and invalid codes on a short list
		issue(REQ_DELETE_AT, 5'd1, 0);
		issue(REQ_DELETE_EQUAL, 5'd0, 0);
		issue(REQ_SEARCH, 5'd0, 0);
		issue(REQ_EXTRACT_MIN, 5'd0, 0);
		issue(REQ_INSERT_AT, 5'd0, 1);
		issue(REQ_INSERT_AT, 5'd2, 1);
		issue(REQ_INSERT_AT, 5'd1, 32'sh80000000);
		issue(REQ_INSERT_AT, 5'd2, 32'sh7fffffff);
		issue(REQ_INSERT_SORTED, 5'd31, -1);
		issue(REQ_INSERT_SORTED, 5'd0, -1);
		issue(REQ_SEARCH, 5'd0, -1);
		issue(REQ_DELETE_AT, 5'd5, 0);
		issue(REQ_DELETE_AT, 5'd0, 0);
		issue(REQ_NONE6, 5'd3, 7);
		issue(REQ_NONE7, 5'd31, -1);
		issue(REQ_DELETE_EQUAL, 5'd0, -1);
		issue(REQ_DELETE_EQUAL, 5'd0, 12345);
		issue(REQ_EXTRACT_MIN, 5'd0, 0);
		// fill to capacity, then overflow, then delete at the tail and by value
		while (held < CAPACITY) issue(REQ_INSERT_SORTED, 5'd0, $urandom_range(0, 3));
		issue(REQ_INSERT_AT, 5'd17, 9);
		issue(REQ_INSERT_SORTED, 5'd0, 9);
		issue(REQ_DELETE_AT, 5'd16, 0);
		issue(REQ_DELETE_EQUAL, 5'd0, 2);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			v = pick_value();
			recent[$urandom_range(0, 7)] = v;
			r = $urandom_range(0, 99);
			// lean towards growth when short, shrink when long, so fullness is visited
			if (r < 30) rq = held < 10 || $urandom_range(0, 1) ? REQ_INSERT_SORTED : REQ_DELETE_AT;
			else if (r < 50) rq = REQ_INSERT_AT;
			else if (r < 65) rq = REQ_DELETE_AT;
			else if (r < 74) rq = REQ_DELETE_EQUAL;
			else if (r < 86) rq = REQ_SEARCH;
			else if (r < 96) rq = REQ_EXTRACT_MIN;
			else rq = req_t'($urandom_range(6, 7));
			if ($urandom_range(0, 9) == 0) issue(rq, 5'($urandom), v);
			else if (rq == REQ_INSERT_AT) issue(rq, 5'($urandom_range(1, held + 1)), v);
			else issue(rq, 5'($urandom_range(1, held > 0 ? held : 1)), v);
		end

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
